// ===== design/dbrm_pkg.sv =====
// Shared codes, widths and defaults of the DMA block ring manager.
`default_nettype none

package dbrm_pkg;

   // Default size of the buffer pool.
   localparam int BUFFER_COUNT_DEFAULT = 8;

   // Request field widths.
   localparam int OPCODE_W  = 3;
   localparam int BLKIDX_W  = 3;
   localparam int COUNT_W   = 32;
   localparam int STATUS_W  = 3;

   // Packed bus widths.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 168;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [1:0]          buf_state_type;

   // Operations.
   localparam opcode_type OP_START   = 3'd0;
   localparam opcode_type OP_LAUNCH  = 3'd1;
   localparam opcode_type OP_DONE    = 3'd2;
   localparam opcode_type OP_TAKE    = 3'd3;
   localparam opcode_type OP_RELEASE = 3'd4;
   localparam opcode_type OP_STOP    = 3'd5;

   // Result status codes.
   localparam status_type RC_OK       = 3'd0;
   localparam status_type RC_INVALID  = 3'd1;
   localparam status_type RC_BUSY     = 3'd2;
   localparam status_type RC_NOSPACE  = 3'd3;
   localparam status_type RC_CALLFAIL = 3'd4;
   localparam status_type RC_EMPTY    = 3'd5;

   // Buffer ownership states.
   localparam buf_state_type BS_FREE  = 2'd0;
   localparam buf_state_type BS_FILL  = 2'd1;
   localparam buf_state_type BS_READY = 2'd2;
   localparam buf_state_type BS_SEND  = 2'd3;

   // Saturating increment of a statistics counter.
   function automatic count_type sat_inc(input count_type value, input logic en);
      count_type res;
      res = value;
      if (en && (value != '1)) begin
         res = value + 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/dma_block_ring_manager.sv =====
// Top level of the DMA block ring manager: buffer pool, ready queue and statistics.
`default_nettype none

// The block tracks a pool of capture buffers (free, filling, ready, sending), a ready queue in
// completion order and four saturating statistics counters. Each request on the req_ stream is
// one operation (start, launch, block done, take, release, stop) and yields exactly one response
// on the rsp_ stream carrying a status, the popped buffer on take, the running flag, the blocks
// still to capture and the counters. A request is taken into an input register, worked
// combinationally (lowest-free search over the pool flags and queue update) and written to the
// response register, so one request is accepted every cycle while rsp_tready stays high. The
// response is presented on rsp_tvalid from the response register, after the input register; while
// rsp_tready is low the response is held, and once the input register is also full req_tready drops.
// The ready queue is a small memory whose head entry is prefetched into a register, with a bypass
// for a write to the entry being read.
// csr_wr_en loads the block count used by start; write it only while no request is in flight.
module dma_block_ring_manager #(
   parameter int BUFFER_COUNT = dbrm_pkg::BUFFER_COUNT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration: capture_blocks.
   input  wire logic                              csr_wr_en,
   input  wire logic [dbrm_pkg::COUNT_W-1:0]      csr_wr_data,
   // Request stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: transfer_error [0], call_failed [1], release_block [4:2], zero [7:5].
   input  wire logic [dbrm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: opcode [2:0], zero [7:3].
   input  wire logic [dbrm_pkg::REQ_USER_W-1:0]   req_tuser,
   // Response stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: status [2:0], block_index [5:3], block_valid [6], running [7],
   // remaining [39:8], produced_count [71:40], sent_count [103:72],
   // dropped_count [135:104], error_count [167:136].
   output logic [dbrm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int IDX_W  = $clog2(BUFFER_COUNT);
   localparam int FILL_W = $clog2(BUFFER_COUNT + 1);

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FILL_W-1:0] fill_type;

   // Configuration register.
   dbrm_pkg::count_type capture_blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_blocks_ff <= '0;
      end else if (csr_wr_en) begin
         capture_blocks_ff <= csr_wr_data;
      end
   end

   // Input register.
   logic                   in_vld_ff, in_vld_in;
   dbrm_pkg::opcode_type   op_ff;
   logic                   xfer_err_ff;
   logic                   call_fail_ff;
   logic [dbrm_pkg::BLKIDX_W-1:0] rel_ff;
   logic                   advance;
   logic                   rsp_vld_ff, rsp_vld_in;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff        <= req_tuser[dbrm_pkg::OPCODE_W-1:0];
         xfer_err_ff  <= req_tdata[0];
         call_fail_ff <= req_tdata[1];
         rel_ff       <= req_tdata[4:2];
      end
   end

   // Control and pool state.
   dbrm_pkg::buf_state_type buf_state_ff [BUFFER_COUNT];
   dbrm_pkg::buf_state_type buf_state_in [BUFFER_COUNT];
   idx_type             head_ff, head_in;
   idx_type             tail_ff, tail_in;
   fill_type            fill_ff, fill_in;
   idx_type             dma_buf_ff, dma_buf_in;
   logic                dma_owns_ff, dma_owns_in;
   logic                active_ff, active_in;
   dbrm_pkg::count_type blocks_left_ff, blocks_left_in;
   dbrm_pkg::count_type produced_ff, produced_in;
   dbrm_pkg::count_type sent_ff, sent_in;
   dbrm_pkg::count_type dropped_ff, dropped_in;
   dbrm_pkg::count_type error_ff, error_in;

   // Ready queue memory with a prefetched head word.
   idx_type fifo_mem [BUFFER_COUNT];
   idx_type head_word_ff;
   logic    push_en;
   idx_type push_data;

   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem[tail_ff] <= push_data;
      end
      if (push_en && (tail_ff == head_in)) begin
         head_word_ff <= push_data;
      end else begin
         head_word_ff <= fifo_mem[head_in];
      end
   end

   // Free flags and lowest free buffer.
   logic [BUFFER_COUNT-1:0] free_vec;
   logic    any_free;
   idx_type first_free;

   always_comb begin
      first_free = '0;
      for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
         free_vec[i] = (buf_state_ff[i] == dbrm_pkg::BS_FREE);
         if (free_vec[i]) begin
            first_free = IDX_W'(i);
         end
      end
      any_free = |free_vec;
   end

   // Helper values for the operations.
   idx_type             head_inc;
   idx_type             tail_inc;
   idx_type             rel_idx;
   logic                rel_in_range;
   dbrm_pkg::count_type blocks_dec;

   assign head_inc     = (head_ff == IDX_W'(BUFFER_COUNT - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc     = (tail_ff == IDX_W'(BUFFER_COUNT - 1)) ? '0 : tail_ff + 1'b1;
   assign rel_idx      = IDX_W'({{IDX_W{1'b0}}, rel_ff});
   assign rel_in_range = (32'(rel_ff) < BUFFER_COUNT);
   assign blocks_dec   = (blocks_left_ff != '0) ? blocks_left_ff - 1'b1 : '0;

   // Operation decode and next state.
   dbrm_pkg::status_type status;
   idx_type blk_idx;
   logic    blk_valid;
   logic    inc_produced, inc_sent, inc_dropped, inc_error;
   logic    clear_stats;

   always_comb begin
      buf_state_in   = buf_state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      dma_buf_in     = dma_buf_ff;
      dma_owns_in    = dma_owns_ff;
      active_in      = active_ff;
      blocks_left_in = blocks_left_ff;
      push_en        = 1'b0;
      push_data      = dma_buf_ff;
      status         = dbrm_pkg::RC_INVALID;
      blk_idx        = '0;
      blk_valid      = 1'b0;
      inc_produced   = 1'b0;
      inc_sent       = 1'b0;
      inc_dropped    = 1'b0;
      inc_error      = 1'b0;
      clear_stats    = 1'b0;
      if (advance) begin
         case (op_ff)
            dbrm_pkg::OP_START: begin
               if (capture_blocks_ff == '0) begin
                  status = dbrm_pkg::RC_INVALID;
               end else if (active_ff || !(&free_vec)) begin
                  status = dbrm_pkg::RC_BUSY;
               end else begin
                  // The pool is all free here, so the lowest free buffer is buffer zero.
                  clear_stats    = 1'b1;
                  blocks_left_in = capture_blocks_ff;
                  head_in        = '0;
                  tail_in        = '0;
                  fill_in        = '0;
                  dma_buf_in     = first_free;
                  if (call_fail_ff) begin
                     dma_owns_in = 1'b0;
                     active_in   = 1'b0;
                     status      = dbrm_pkg::RC_CALLFAIL;
                  end else begin
                     buf_state_in[first_free] = dbrm_pkg::BS_FILL;
                     dma_owns_in = 1'b1;
                     active_in   = 1'b1;
                     status      = dbrm_pkg::RC_OK;
                  end
               end
            end
            dbrm_pkg::OP_LAUNCH: begin
               status = dbrm_pkg::RC_OK;
               if (active_ff && call_fail_ff) begin
                  inc_error   = 1'b1;
                  active_in   = 1'b0;
                  dma_owns_in = 1'b0;
                  if (dma_owns_ff) begin
                     buf_state_in[dma_buf_ff] = dbrm_pkg::BS_FREE;
                  end
                  status = dbrm_pkg::RC_CALLFAIL;
               end
            end
            dbrm_pkg::OP_DONE: begin
               if (!dma_owns_ff) begin
                  status = dbrm_pkg::RC_INVALID;
               end else begin
                  inc_produced = 1'b1;
                  inc_error    = xfer_err_ff;
                  if (32'(fill_ff) < BUFFER_COUNT) begin
                     push_en = 1'b1;
                     tail_in = tail_inc;
                     fill_in = fill_ff + 1'b1;
                  end
                  buf_state_in[dma_buf_ff] = dbrm_pkg::BS_READY;
                  dma_owns_in    = 1'b0;
                  blocks_left_in = blocks_dec;
                  if ((blocks_dec == '0) || xfer_err_ff) begin
                     active_in = 1'b0;
                     status    = dbrm_pkg::RC_OK;
                  end else if (!any_free) begin
                     inc_dropped = 1'b1;
                     active_in   = 1'b0;
                     status      = dbrm_pkg::RC_NOSPACE;
                  end else if (call_fail_ff) begin
                     // The reload failed: the claimed buffer goes straight back.
                     dma_buf_in = first_free;
                     inc_error  = 1'b1;
                     active_in  = 1'b0;
                     status     = dbrm_pkg::RC_CALLFAIL;
                  end else begin
                     buf_state_in[first_free] = dbrm_pkg::BS_FILL;
                     dma_buf_in  = first_free;
                     dma_owns_in = 1'b1;
                     status      = dbrm_pkg::RC_OK;
                  end
               end
            end
            dbrm_pkg::OP_TAKE: begin
               if (fill_ff == '0) begin
                  status = dbrm_pkg::RC_EMPTY;
               end else begin
                  blk_idx   = head_word_ff;
                  blk_valid = 1'b1;
                  head_in   = head_inc;
                  fill_in   = fill_ff - 1'b1;
                  buf_state_in[head_word_ff] = dbrm_pkg::BS_SEND;
                  status    = dbrm_pkg::RC_OK;
               end
            end
            dbrm_pkg::OP_RELEASE: begin
               if (rel_in_range && (buf_state_ff[rel_idx] == dbrm_pkg::BS_SEND)) begin
                  buf_state_in[rel_idx] = dbrm_pkg::BS_FREE;
                  inc_sent = 1'b1;
                  status   = dbrm_pkg::RC_OK;
               end
            end
            dbrm_pkg::OP_STOP: begin
               active_in   = 1'b0;
               dma_owns_in = 1'b0;
               if (dma_owns_ff) begin
                  buf_state_in[dma_buf_ff] = dbrm_pkg::BS_FREE;
               end
               status = dbrm_pkg::RC_OK;
            end
            default: begin
               status = dbrm_pkg::RC_INVALID;
            end
         endcase
      end
   end

   // Saturating statistics, cleared by an accepted start.
   always_comb begin
      if (clear_stats) begin
         produced_in = '0;
         sent_in     = '0;
         dropped_in  = '0;
         error_in    = '0;
      end else begin
         produced_in = dbrm_pkg::sat_inc(produced_ff, inc_produced);
         sent_in     = dbrm_pkg::sat_inc(sent_ff, inc_sent);
         dropped_in  = dbrm_pkg::sat_inc(dropped_ff, inc_dropped);
         error_in    = dbrm_pkg::sat_inc(error_ff, inc_error);
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFER_COUNT; i++) begin
            buf_state_ff[i] <= dbrm_pkg::BS_FREE;
         end
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         dma_buf_ff     <= '0;
         dma_owns_ff    <= 1'b0;
         active_ff      <= 1'b0;
         blocks_left_ff <= '0;
         produced_ff    <= '0;
         sent_ff        <= '0;
         dropped_ff     <= '0;
         error_ff       <= '0;
      end else begin
         buf_state_ff   <= buf_state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         fill_ff        <= fill_in;
         dma_buf_ff     <= dma_buf_in;
         dma_owns_ff    <= dma_owns_in;
         active_ff      <= active_in;
         blocks_left_ff <= blocks_left_in;
         produced_ff    <= produced_in;
         sent_ff        <= sent_in;
         dropped_ff     <= dropped_in;
         error_ff       <= error_in;
      end
   end

   // Response register.
   logic [dbrm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign rsp_vld_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {error_in, dropped_in, sent_in, produced_in, blocks_left_in,
                         active_in, blk_valid,
                         dbrm_pkg::BLKIDX_W'({{dbrm_pkg::BLKIDX_W{1'b0}}, blk_idx}),
                         status};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/dbrm_checker.sv =====
// Port-level checks for the DMA block ring manager and their binding.
`default_nettype none

module dbrm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [dbrm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   dbrm_pkg::status_type rsp_status;
   logic                 rsp_blk_valid;
   logic                 rsp_running;
   dbrm_pkg::count_type  rsp_remaining;

   assign rsp_status    = rsp_tdata[2:0];
   assign rsp_blk_valid = rsp_tdata[6];
   assign rsp_running   = rsp_tdata[7];
   assign rsp_remaining = rsp_tdata[39:8];

   // No response may be pending right after reset.
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A popped buffer only comes with an ok status.
   a_take_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_blk_valid |-> rsp_status == dbrm_pkg::RC_OK)
      else $error("block_valid with a failing status");

   // Status is always one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_status == dbrm_pkg::RC_OK || rsp_status == dbrm_pkg::RC_INVALID ||
                     rsp_status == dbrm_pkg::RC_BUSY || rsp_status == dbrm_pkg::RC_NOSPACE ||
                     rsp_status == dbrm_pkg::RC_CALLFAIL || rsp_status == dbrm_pkg::RC_EMPTY)
      else $error("undefined status code");

   // A running capture always has blocks left to capture.
   a_running_remaining: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_running |-> rsp_remaining != '0)
      else $error("capture running with no blocks remaining");

endmodule

bind dma_block_ring_manager dbrm_checker u_dbrm_checker (.*);

`default_nettype wire

// ===== dv/dma_block_ring_manager_tb.sv =====
// Self-checking testbench of the DMA block ring manager: directed table, then random traffic.
`timescale 1ns / 100ps

module dma_block_ring_manager_tb;

   localparam int BUFFER_COUNT   = dbrm_pkg::BUFFER_COUNT_DEFAULT;
   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int DIR_ROWS       = 25;
   localparam int PHASES         = 8;
   localparam int RAND_PER_PHASE = 210;
   localparam int LONG_HOLD      = 300;
   localparam int END_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // Opcodes the block does not define; they must be refused.
   localparam dbrm_pkg::opcode_type OP_UNUSED_6 = 3'd6;
   localparam dbrm_pkg::opcode_type OP_UNUSED_7 = 3'd7;

   typedef logic [dbrm_pkg::BLKIDX_W-1:0] blk_idx_type;

   typedef struct packed {
      dbrm_pkg::opcode_type opcode;
      logic                 xfer_err;
      logic                 call_fail;
      blk_idx_type          rel_idx;
   } ring_op_type;

   typedef struct packed {
      dbrm_pkg::status_type status;
      blk_idx_type          block_index;
      logic                 block_valid;
      logic                 running;
      dbrm_pkg::count_type  remaining;
      dbrm_pkg::count_type  produced;
      dbrm_pkg::count_type  sent;
      dbrm_pkg::count_type  dropped;
      dbrm_pkg::count_type  errors;
   } ring_report_type;

   typedef struct packed {
      ring_op_type          op;
      logic                 cfg_write;
      dbrm_pkg::count_type  cfg_value;
      logic                 has_status;
      dbrm_pkg::status_type exp_status;
   } dir_row_type;

   // Block ports.
   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            csr_wr_en   = 1'b0;
   logic [dbrm_pkg::COUNT_W-1:0]    csr_wr_data = '0;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [dbrm_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [dbrm_pkg::REQ_USER_W-1:0] req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [dbrm_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // Mirror of the block state used for prediction.
   dbrm_pkg::buf_state_type pool_state [BUFFER_COUNT];
   blk_idx_type             ready_ring [BUFFER_COUNT];
   int                      q_head = 0;
   int                      q_tail = 0;
   int                      q_fill = 0;
   blk_idx_type             dma_idx = '0;
   logic                    dma_holds = 1'b0;
   logic                    capturing = 1'b0;
   dbrm_pkg::count_type     blocks_left = '0;
   dbrm_pkg::count_type     produced_cnt = '0;
   dbrm_pkg::count_type     sent_cnt = '0;
   dbrm_pkg::count_type     dropped_cnt = '0;
   dbrm_pkg::count_type     error_cnt = '0;
   dbrm_pkg::count_type     capture_cfg = '0;

   ring_report_type     reports_due [$];
   dir_row_type         directed_rows [DIR_ROWS];
   dbrm_pkg::count_type phase_cfg [PHASES];

   int   fail_count = 0;
   int   sender_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_trigger = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   dma_block_ring_manager #(
      .BUFFER_COUNT(BUFFER_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         pool_state[i] = dbrm_pkg::BS_FREE;
         ready_ring[i] = '0;
      end
   end

   // Statistics counters stick at all ones.
   function automatic dbrm_pkg::count_type count_up(input dbrm_pkg::count_type value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   // Claims the lowest free buffer for DMA; -1 when none is free.
   task automatic claim_lowest(output int idx);
      idx = -1;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         if (idx < 0 && pool_state[i] == dbrm_pkg::BS_FREE) begin
            pool_state[i] = dbrm_pkg::BS_FILL;
            idx = i;
         end
      end
   endtask

   // Hands the DMA buffer back to the pool, but only if DMA holds one.
   task automatic free_dma_buffer;
      if (dma_holds) begin
         pool_state[dma_idx] = dbrm_pkg::BS_FREE;
      end
      dma_holds = 1'b0;
   endtask

   // Applies one request to the mirror state and builds the report it should produce.
   task automatic apply_ring_op(input ring_op_type r, output ring_report_type e);
      int          claimed;
      logic        pool_idle;
      blk_idx_type finished;
      e = '0;
      e.status = dbrm_pkg::RC_INVALID;
      case (r.opcode)
         dbrm_pkg::OP_START: begin
            pool_idle = 1'b1;
            for (int i = 0; i < BUFFER_COUNT; i++) begin
               if (pool_state[i] != dbrm_pkg::BS_FREE) pool_idle = 1'b0;
            end
            if (capture_cfg == '0) begin
               e.status = dbrm_pkg::RC_INVALID;
            end else if (capturing || !pool_idle) begin
               e.status = dbrm_pkg::RC_BUSY;
            end else begin
               produced_cnt = '0;
               sent_cnt = '0;
               dropped_cnt = '0;
               error_cnt = '0;
               capturing = 1'b1;
               blocks_left = capture_cfg;
               q_head = 0;
               q_tail = 0;
               q_fill = 0;
               // The whole pool is free here, so the claim always succeeds.
               claim_lowest(claimed);
               dma_idx = blk_idx_type'(claimed);
               dma_holds = 1'b1;
               if (r.call_fail) begin
                  free_dma_buffer();
                  capturing = 1'b0;
                  e.status = dbrm_pkg::RC_CALLFAIL;
               end else begin
                  e.status = dbrm_pkg::RC_OK;
               end
            end
         end
         dbrm_pkg::OP_LAUNCH: begin
            e.status = dbrm_pkg::RC_OK;
            if (capturing && r.call_fail) begin
               error_cnt = count_up(error_cnt);
               capturing = 1'b0;
               free_dma_buffer();
               e.status = dbrm_pkg::RC_CALLFAIL;
            end
         end
         dbrm_pkg::OP_DONE: begin
            if (dma_holds) begin
               finished = dma_idx;
               produced_cnt = count_up(produced_cnt);
               if (r.xfer_err) error_cnt = count_up(error_cnt);
               if (q_fill < BUFFER_COUNT) begin
                  ready_ring[q_tail] = finished;
                  q_tail = (q_tail + 1) % BUFFER_COUNT;
                  q_fill++;
               end
               pool_state[finished] = dbrm_pkg::BS_READY;
               dma_holds = 1'b0;
               if (blocks_left != '0) blocks_left = blocks_left - 1'b1;
               if (blocks_left == '0 || r.xfer_err) begin
                  capturing = 1'b0;
                  e.status = dbrm_pkg::RC_OK;
               end else begin
                  claim_lowest(claimed);
                  if (claimed < 0) begin
                     // Every buffer is still queued or out: the capture is dropped.
                     dropped_cnt = count_up(dropped_cnt);
                     capturing = 1'b0;
                     e.status = dbrm_pkg::RC_NOSPACE;
                  end else begin
                     dma_idx = blk_idx_type'(claimed);
                     dma_holds = 1'b1;
                     e.status = dbrm_pkg::RC_OK;
                     if (r.call_fail) begin
                        error_cnt = count_up(error_cnt);
                        free_dma_buffer();
                        capturing = 1'b0;
                        e.status = dbrm_pkg::RC_CALLFAIL;
                     end
                  end
               end
            end
         end
         dbrm_pkg::OP_TAKE: begin
            if (q_fill == 0) begin
               e.status = dbrm_pkg::RC_EMPTY;
            end else begin
               e.block_index = ready_ring[q_head];
               q_head = (q_head + 1) % BUFFER_COUNT;
               q_fill--;
               pool_state[e.block_index] = dbrm_pkg::BS_SEND;
               e.block_valid = 1'b1;
               e.status = dbrm_pkg::RC_OK;
            end
         end
         dbrm_pkg::OP_RELEASE: begin
            if (pool_state[r.rel_idx] == dbrm_pkg::BS_SEND) begin
               pool_state[r.rel_idx] = dbrm_pkg::BS_FREE;
               sent_cnt = count_up(sent_cnt);
               e.status = dbrm_pkg::RC_OK;
            end
         end
         dbrm_pkg::OP_STOP: begin
            capturing = 1'b0;
            free_dma_buffer();
            e.status = dbrm_pkg::RC_OK;
         end
         default: e.status = dbrm_pkg::RC_INVALID;
      endcase
      e.running = capturing;
      e.remaining = blocks_left;
      e.produced = produced_cnt;
      e.sent = sent_cnt;
      e.dropped = dropped_cnt;
      e.errors = error_cnt;
   endtask

   // Picks a request that mostly follows a sensible capture flow, with some noise mixed in.
   function automatic ring_op_type pick_request();
      ring_op_type r;
      int          roll;
      int          sending_cnt;
      int          pick;
      logic        pool_idle;
      r.opcode = dbrm_pkg::OP_STOP;
      r.xfer_err = ($urandom_range(19) == 0);
      r.call_fail = ($urandom_range(19) == 0);
      r.rel_idx = blk_idx_type'($urandom_range(BUFFER_COUNT - 1));
      sending_cnt = 0;
      pick = 0;
      pool_idle = 1'b1;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         if (pool_state[i] != dbrm_pkg::BS_FREE) pool_idle = 1'b0;
         if (pool_state[i] == dbrm_pkg::BS_SEND) begin
            sending_cnt++;
            if ($urandom_range(sending_cnt - 1) == 0) pick = i;
         end
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
         // Noise: any opcode, any flag, any buffer index.
         r.opcode = dbrm_pkg::opcode_type'($urandom_range(7));
         r.xfer_err = 1'($urandom_range(1));
         r.call_fail = 1'($urandom_range(1));
         return r;
      end
      roll = $urandom_range(99);
      if (capturing) begin
         if (roll < 55) r.opcode = dbrm_pkg::OP_DONE;
         else if (roll < 65) r.opcode = dbrm_pkg::OP_LAUNCH;
         else if (roll < 78) r.opcode = dbrm_pkg::OP_TAKE;
         else if (roll < 93) r.opcode = (sending_cnt > 0) ? dbrm_pkg::OP_RELEASE
                                                          : dbrm_pkg::OP_TAKE;
         else if (roll < 96) r.opcode = dbrm_pkg::OP_STOP;
         else r.opcode = dbrm_pkg::OP_START;
      end else if (pool_idle) begin
         if (roll < 80) r.opcode = dbrm_pkg::OP_START;
         else if (roll < 90) r.opcode = dbrm_pkg::OP_LAUNCH;
         else r.opcode = dbrm_pkg::OP_TAKE;
      end else begin
         // Capture has ended: the consumer drains what is left.
         if (roll < 45) r.opcode = dbrm_pkg::OP_TAKE;
         else if (roll < 90) r.opcode = (sending_cnt > 0) ? dbrm_pkg::OP_RELEASE
                                                          : dbrm_pkg::OP_TAKE;
         else r.opcode = dbrm_pkg::OP_START;
      end
      if (r.opcode == dbrm_pkg::OP_RELEASE) r.rel_idx = blk_idx_type'(pick);
      return r;
   endfunction

   function automatic dir_row_type make_row(input dbrm_pkg::opcode_type opcode,
                                            input logic xfer_err, input logic call_fail,
                                            input blk_idx_type rel_idx, input logic cfg_write,
                                            input dbrm_pkg::count_type cfg_value,
                                            input logic has_status,
                                            input dbrm_pkg::status_type exp_status);
      dir_row_type row;
      row.op.opcode = opcode;
      row.op.xfer_err = xfer_err;
      row.op.call_fail = call_fail;
      row.op.rel_idx = rel_idx;
      row.cfg_write = cfg_write;
      row.cfg_value = cfg_value;
      row.has_status = has_status;
      row.exp_status = exp_status;
      return row;
   endfunction

   // Drops valid and waits until every outstanding request has been answered.
   task automatic drain_reports;
      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
   endtask

   // Loads capture_blocks while the block is idle.
   task automatic write_capture_blocks(input dbrm_pkg::count_type value);
      drain_reports();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capture_cfg = value;
   endtask

   // Offers one request after a random gap and records its predicted report on acceptance.
   task automatic send_request(input ring_op_type r, input logic has_status,
                               input dbrm_pkg::status_type exp_status);
      ring_report_type e;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(dbrm_pkg::REQ_DATA_W - dbrm_pkg::BLKIDX_W - 2){1'b0}},
                    r.rel_idx, r.call_fail, r.xfer_err};
      req_tuser <= {{(dbrm_pkg::REQ_USER_W - dbrm_pkg::OPCODE_W){1'b0}}, r.opcode};
      do @(posedge clock); while (!req_tready);
      apply_ring_op(r, e);
      // Directed rows with a status read straight off the spec check it as typed.
      if (has_status) e.status = exp_status;
      reports_due.push_back(e);
   endtask

   task automatic compare_field(input string name,
                                input logic [dbrm_pkg::COUNT_W-1:0] exp_v,
                                input logic [dbrm_pkg::COUNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Compares an accepted report with the oldest prediction.
   task automatic check_report;
      ring_report_type e;
      if (reports_due.size() == 0) begin
         $error("report with no request outstanding: 0x%0h", rsp_tdata);
         fail_count++;
      end else begin
         e = reports_due.pop_front();
         compare_field("status", dbrm_pkg::COUNT_W'(e.status),
                       dbrm_pkg::COUNT_W'(rsp_tdata[2:0]));
         compare_field("block_index", dbrm_pkg::COUNT_W'(e.block_index),
                       dbrm_pkg::COUNT_W'(rsp_tdata[5:3]));
         compare_field("block_valid", dbrm_pkg::COUNT_W'(e.block_valid),
                       dbrm_pkg::COUNT_W'(rsp_tdata[6]));
         compare_field("running", dbrm_pkg::COUNT_W'(e.running),
                       dbrm_pkg::COUNT_W'(rsp_tdata[7]));
         compare_field("remaining", e.remaining, rsp_tdata[39:8]);
         compare_field("produced_count", e.produced, rsp_tdata[71:40]);
         compare_field("sent_count", e.sent, rsp_tdata[103:72]);
         compare_field("dropped_count", e.dropped, rsp_tdata[135:104]);
         compare_field("error_count", e.errors, rsp_tdata[167:136]);
      end
   endtask

   // Report side: check what arrives, then decide whether to stall next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_report();
         if (hold_trigger && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: too long without any handshake on either side ends the run.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dma_block_ring_manager verification failed");
         $finish;
      end
   end

   initial begin
      // Directed table: each operation and each refusal but no-space, with obvious statuses typed in.
      directed_rows[0]  = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_INVALID);
      directed_rows[1]  = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b1, 32'd3,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[2]  = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_BUSY);
      directed_rows[3]  = make_row(dbrm_pkg::OP_LAUNCH, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[4]  = make_row(dbrm_pkg::OP_DONE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);
      directed_rows[5]  = make_row(dbrm_pkg::OP_TAKE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[6]  = make_row(dbrm_pkg::OP_RELEASE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[7]  = make_row(dbrm_pkg::OP_RELEASE, 1'b0, 1'b0, 3'd7, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_INVALID);
      directed_rows[8]  = make_row(dbrm_pkg::OP_DONE, 1'b0, 1'b1, 3'd0, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);
      directed_rows[9]  = make_row(dbrm_pkg::OP_TAKE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[10] = make_row(dbrm_pkg::OP_TAKE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_EMPTY);
      directed_rows[11] = make_row(dbrm_pkg::OP_RELEASE, 1'b0, 1'b0, 3'd1, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);
      directed_rows[12] = make_row(dbrm_pkg::OP_DONE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_INVALID);
      directed_rows[13] = make_row(OP_UNUSED_6, 1'b1, 1'b1, 3'd7, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_INVALID);
      directed_rows[14] = make_row(OP_UNUSED_7, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_INVALID);
      directed_rows[15] = make_row(dbrm_pkg::OP_START, 1'b0, 1'b1, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_CALLFAIL);
      directed_rows[16] = make_row(dbrm_pkg::OP_LAUNCH, 1'b0, 1'b1, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[17] = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[18] = make_row(dbrm_pkg::OP_LAUNCH, 1'b0, 1'b1, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_CALLFAIL);
      directed_rows[19] = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[20] = make_row(dbrm_pkg::OP_STOP, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[21] = make_row(dbrm_pkg::OP_START, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b1, dbrm_pkg::RC_OK);
      directed_rows[22] = make_row(dbrm_pkg::OP_DONE, 1'b1, 1'b0, 3'd0, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);
      directed_rows[23] = make_row(dbrm_pkg::OP_TAKE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);
      directed_rows[24] = make_row(dbrm_pkg::OP_RELEASE, 1'b0, 1'b0, 3'd0, 1'b0, '0,
                                   1'b0, dbrm_pkg::RC_OK);

      // Block counts per random phase, the extremes among them.
      phase_cfg[0] = 32'd1;
      phase_cfg[1] = '1;
      phase_cfg[2] = 32'd9;
      phase_cfg[3] = 32'd2;
      phase_cfg[4] = '0;
      phase_cfg[5] = 32'd5;
      phase_cfg[6] = dbrm_pkg::count_type'($urandom);
      phase_cfg[7] = 32'd3;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIR_ROWS; k++) begin
         if (directed_rows[k].cfg_write) write_capture_blocks(directed_rows[k].cfg_value);
         send_request(directed_rows[k].op, directed_rows[k].has_status,
                      directed_rows[k].exp_status);
      end

      // Random phases, each with its own block count and idling pattern.
      for (int p = 0; p < PHASES; p++) begin
         write_capture_blocks(phase_cfg[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin sender_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // The receiver holds off while requests keep coming, so the block backs up.
            if (p == 0 && n == 40) hold_trigger = 1'b1;
            // The sender goes quiet once until every report is back.
            if (p == 1 && n == RAND_PER_PHASE / 2) drain_reports();
            send_request(pick_request(), 1'b0, dbrm_pkg::RC_OK);
         end
      end

      drain_reports();
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("dma_block_ring_manager verification clean");
      end else begin
         $display("dma_block_ring_manager verification failed");
      end
      $finish;
   end

endmodule
